FILE: sv/lcg_pkg.sv
// ----------------------------------------------------------------------------
// lcg_pkg: shared types and constants of the linear chirp generator
// Field widths, register indexes and the pipeline control word.
// ----------------------------------------------------------------------------
`default_nettype none

package lcg_pkg;

   localparam int unsigned REG_WIDTH    = 32;
   localparam int unsigned CSR_IDX_BITS = 2;
   localparam int unsigned LEN_WIDTH    = 24;
   localparam int unsigned INDEX_WIDTH  = 24;
   localparam int unsigned SAMPLE_WIDTH = 16;
   localparam int unsigned TABLE_WIDTH  = 15;

   // pi/2 in Q2.30, argument scale of the cosine table series.
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_FIRST_STEP   = 2'd0,
      CSR_STEP_GROWTH  = 2'd1,
      CSR_SWEEP_LENGTH = 2'd2,
      CSR_UNUSED       = 2'd3
   } csr_index_type;

   // Control word that travels with a sample down the pipeline.
   typedef struct packed {
      logic                   valid;
      logic                   negate;
      logic                   last;
      logic [INDEX_WIDTH-1:0] index;
   } sample_ctl_type;

endpackage

`default_nettype wire

FILE: sv/lcg_sweep.sv
// ----------------------------------------------------------------------------
// lcg_sweep: sweep sequencer and second-order phase accumulator
// Holds phase, phase step, position and the running flag; registers the
// table address and control word of each emitted sample.
// ----------------------------------------------------------------------------
`default_nettype none

module lcg_sweep #(
   parameter int unsigned PHASE_BITS      = 32,
   parameter int unsigned TABLE_ADDR_BITS = 10,
   parameter int unsigned LENGTH_BITS     = 24
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               advance,
   input  wire logic                               req_fire,
   input  wire logic                               req_restart,
   input  wire logic [lcg_pkg::REG_WIDTH-1:0]      first_step,
   input  wire logic [lcg_pkg::REG_WIDTH-1:0]      step_growth,
   input  wire logic [lcg_pkg::LEN_WIDTH-1:0]      sweep_length,
   output lcg_pkg::sample_ctl_type                 s1_ctl,
   output logic [TABLE_ADDR_BITS:0]                s1_addr
);

   localparam int unsigned RW = lcg_pkg::REG_WIDTH;

   logic [PHASE_BITS-1:0]  phase_acc_ff, phase_acc_in;
   logic [PHASE_BITS-1:0]  step_acc_ff, step_acc_in;
   logic [LENGTH_BITS-1:0] position_ff, position_in;
   logic                   running_ff, running_in;

   lcg_pkg::sample_ctl_type        ctl_ff, ctl_in;
   logic [TABLE_ADDR_BITS:0]       addr_ff, addr_in;

   logic [PHASE_BITS-1:0]  cur_phase, cur_step, first_al, growth_al;
   logic [LENGTH_BITS-1:0] cur_pos, len;
   logic                   live, last;
   logic [1:0]             quad;
   logic [TABLE_ADDR_BITS-1:0] k;
   logic [PHASE_BITS+RW-1:0]   first_wide, growth_wide;
   logic [LENGTH_BITS+lcg_pkg::LEN_WIDTH-1:0]   len_wide;
   logic [LENGTH_BITS+lcg_pkg::INDEX_WIDTH-1:0] idx_wide;

   // Q0.32 register scaled to the phase width: value * 2^PHASE_BITS / 2^32,
   // rounded toward minus infinity and wrapped.
   assign first_wide  = {{PHASE_BITS{first_step[RW-1]}}, first_step} << PHASE_BITS;
   assign growth_wide = {{PHASE_BITS{step_growth[RW-1]}}, step_growth} << PHASE_BITS;
   assign first_al    = first_wide[PHASE_BITS+RW-1:RW];
   assign growth_al   = growth_wide[PHASE_BITS+RW-1:RW];

   assign len_wide = {{LENGTH_BITS{1'b0}}, sweep_length};
   assign len      = len_wide[LENGTH_BITS-1:0];

   always_comb begin
      cur_phase = req_restart ? '0 : phase_acc_ff;
      cur_step  = req_restart ? first_al : step_acc_ff;
      cur_pos   = req_restart ? '0 : position_ff;
      live      = req_restart ? (len != '0) : running_ff;
      last      = ({1'b0, cur_pos} + {{LENGTH_BITS{1'b0}}, 1'b1}) >= {1'b0, len};
      quad      = cur_phase[PHASE_BITS-1 -: 2];
      k         = cur_phase[PHASE_BITS-3 -: TABLE_ADDR_BITS];
   end

   assign idx_wide = {{lcg_pkg::INDEX_WIDTH{1'b0}}, cur_pos};

   always_comb begin
      phase_acc_in = phase_acc_ff;
      step_acc_in  = step_acc_ff;
      position_in  = position_ff;
      running_in   = running_ff;
      if (req_fire) begin
         if (live) begin
            phase_acc_in = cur_phase + cur_step;
            step_acc_in  = cur_step + growth_al;
            position_in  = cur_pos + {{(LENGTH_BITS-1){1'b0}}, 1'b1};
            running_in   = !last;
         end else if (req_restart) begin
            phase_acc_in = '0;
            step_acc_in  = first_al;
            position_in  = '0;
            running_in   = 1'b0;
         end
      end
   end

   always_comb begin
      ctl_in.valid  = req_fire && live;
      ctl_in.negate = (quad == 2'd1) || (quad == 2'd2);
      ctl_in.last   = last;
      ctl_in.index  = idx_wide[lcg_pkg::INDEX_WIDTH-1:0];
      // Odd quadrants read the table mirrored about the quarter wave.
      if (quad[0]) begin
         addr_in = {1'b1, {TABLE_ADDR_BITS{1'b0}}} - {1'b0, k};
      end else begin
         addr_in = {1'b0, k};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_acc_ff <= '0;
         step_acc_ff  <= '0;
         position_ff  <= '0;
         running_ff   <= 1'b0;
      end else begin
         phase_acc_ff <= phase_acc_in;
         step_acc_ff  <= step_acc_in;
         position_ff  <= position_in;
         running_ff   <= running_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (advance) begin
         ctl_ff.valid <= ctl_in.valid;
      end
      if (advance) begin
         ctl_ff.negate <= ctl_in.negate;
         ctl_ff.last   <= ctl_in.last;
         ctl_ff.index  <= ctl_in.index;
         addr_ff       <= addr_in;
      end
   end

   assign s1_ctl  = ctl_ff;
   assign s1_addr = addr_ff;

endmodule

`default_nettype wire

FILE: sv/lcg_cos_rom.sv
// ----------------------------------------------------------------------------
// lcg_cos_rom: quarter-wave cosine table with registered read
// Entries are 16384*cos(pi*k/(2Q)), k = 0..Q, built at elaboration.
// ----------------------------------------------------------------------------
`default_nettype none

module lcg_cos_rom #(
   parameter int unsigned TABLE_ADDR_BITS = 10
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                advance,
   input  wire lcg_pkg::sample_ctl_type             s1_ctl,
   input  wire logic [TABLE_ADDR_BITS:0]            s1_addr,
   output lcg_pkg::sample_ctl_type                  s2_ctl,
   output logic [lcg_pkg::TABLE_WIDTH-1:0]          s2_data
);

   localparam int unsigned QSIZE = 1 << TABLE_ADDR_BITS;

   typedef logic [lcg_pkg::TABLE_WIDTH-1:0] rom_type [0:QSIZE];

   // Q30 Taylor series of cos, thirteen terms, rounded to Q14.
   function automatic rom_type build_table();
      rom_type            t;
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic [63:0]        rounded;
      int                 i;
      int                 n;
      for (i = 0; i <= QSIZE; i++) begin
         x    = (lcg_pkg::HALF_PI_Q30 * 64'(i)) >> TABLE_ADDR_BITS;
         x2   = (x * x) >> 30;
         term = 64'd1 << 30;
         sum  = signed'(term);
         for (n = 1; n <= 12; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
            if (n % 2 == 1) begin
               sum = sum - signed'(term);
            end else begin
               sum = sum + signed'(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         rounded = (unsigned'(sum) + 64'd32768) >> 16;
         t[i]    = rounded[lcg_pkg::TABLE_WIDTH-1:0];
      end
      return t;
   endfunction

   localparam rom_type COS_ROM = build_table();

   lcg_pkg::sample_ctl_type            ctl_ff;
   logic [lcg_pkg::TABLE_WIDTH-1:0]    data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (advance) begin
         ctl_ff.valid <= s1_ctl.valid;
      end
      if (advance) begin
         ctl_ff.negate <= s1_ctl.negate;
         ctl_ff.last   <= s1_ctl.last;
         ctl_ff.index  <= s1_ctl.index;
         data_ff       <= COS_ROM[s1_addr];
      end
   end

   assign s2_ctl  = ctl_ff;
   assign s2_data = data_ff;

endmodule

`default_nettype wire

FILE: sv/linear_chirp_generator_core.sv
// ----------------------------------------------------------------------------
// linear_chirp_generator_core: linear FM chirp source, 0.5*cos of a
// second-order phase accumulator
//
// Each transfer on the req_ channel is one tick. req_restart=1 starts a new
// sweep and emits sample 0 unless the sweep length is zero; req_restart=0
// emits the next sample of the running sweep, or nothing when no sweep
// runs. The final sample of a sweep carries rsp_last_sample. Registers are
// written over the csr_ channel, which is always ready; write them only
// while the block is idle. Throughput is one tick per cycle while the
// pipeline is not held. A sample passes the phase accumulator stage, then
// the registered cosine table read. When rsp_ready is low with a sample
// waiting, the whole pipeline holds and req_ready drops in the same cycle;
// ticks that give no sample still pass through as empty slots. Reset clears
// all registers, the sweep state and the pipeline; no sweep runs after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_chirp_generator_core #(
   parameter int unsigned PHASE_BITS      = 32,
   parameter int unsigned TABLE_ADDR_BITS = 10,
   parameter int unsigned LENGTH_BITS     = 24
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic                                   req_restart,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic signed [lcg_pkg::SAMPLE_WIDTH-1:0]     rsp_sample_value,
   output logic [lcg_pkg::INDEX_WIDTH-1:0]             rsp_sample_index,
   output logic                                        rsp_last_sample,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [lcg_pkg::CSR_IDX_BITS-1:0]       csr_index,
   input  wire logic [lcg_pkg::REG_WIDTH-1:0]          csr_wdata
);

   logic [lcg_pkg::REG_WIDTH-1:0] first_step_ff;
   logic [lcg_pkg::REG_WIDTH-1:0] step_growth_ff;
   logic [lcg_pkg::LEN_WIDTH-1:0] sweep_length_ff;

   logic                              advance;
   logic                              req_fire;
   lcg_pkg::sample_ctl_type           s1_ctl;
   lcg_pkg::sample_ctl_type           s2_ctl;
   logic [TABLE_ADDR_BITS:0]          s1_addr;
   logic [lcg_pkg::TABLE_WIDTH-1:0]   s2_data;
   logic [lcg_pkg::SAMPLE_WIDTH-1:0]  magnitude;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_step_ff   <= '0;
         step_growth_ff  <= '0;
         sweep_length_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (lcg_pkg::csr_index_type'(csr_index))
            lcg_pkg::CSR_FIRST_STEP:   first_step_ff   <= csr_wdata;
            lcg_pkg::CSR_STEP_GROWTH:  step_growth_ff  <= csr_wdata;
            lcg_pkg::CSR_SWEEP_LENGTH: sweep_length_ff <= csr_wdata[lcg_pkg::LEN_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // The pipeline moves as one whenever the output slot is free or drains.
   assign advance   = !s2_ctl.valid || rsp_ready;
   assign req_ready = advance;
   assign req_fire  = req_valid && req_ready;

   lcg_sweep #(
      .PHASE_BITS      (PHASE_BITS),
      .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
      .LENGTH_BITS     (LENGTH_BITS)
   ) u_sweep (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .req_fire     (req_fire),
      .req_restart  (req_restart),
      .first_step   (first_step_ff),
      .step_growth  (step_growth_ff),
      .sweep_length (sweep_length_ff),
      .s1_ctl       (s1_ctl),
      .s1_addr      (s1_addr)
   );

   lcg_cos_rom #(
      .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
   ) u_cos_rom (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .s1_ctl  (s1_ctl),
      .s1_addr (s1_addr),
      .s2_ctl  (s2_ctl),
      .s2_data (s2_data)
   );

   assign magnitude        = {1'b0, s2_data};
   assign rsp_valid        = s2_ctl.valid;
   assign rsp_sample_value = s2_ctl.negate ? signed'(-magnitude) : signed'(magnitude);
   assign rsp_sample_index = s2_ctl.index;
   assign rsp_last_sample  = s2_ctl.last;

   // A restart with a nonzero length always produces sample 0 one stage on.
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_restart && (sweep_length_ff != '0))
      |=> (s1_ctl.valid && (s1_ctl.index == '0)))
      else $error("restart did not emit sample zero");

   // A restart with zero length never produces a sample.
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_restart && (sweep_length_ff == '0)) |=> !s1_ctl.valid)
      else $error("zero-length sweep emitted a sample");

   // Sample magnitude stays within half scale.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_sample_value >= -16'sd16384) && (rsp_sample_value <= 16'sd16384)))
      else $error("sample value out of range");

   // Reset empties the pipeline.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

`default_nettype wire
